>>> rtl/rdns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdns_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int SLOTS       = MAX_ENTRIES + 2;
	localparam int IDX_W       = $clog2(SLOTS);
	localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);
	localparam int FIELD_W     = 11;
	localparam int NUM_RST     = 1024;

	localparam logic FUNC_DELETE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [FIELD_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (int'(v) > MAX_ENTRIES) begin
			r = LEN_W'(MAX_ENTRIES);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/range_delete_nearest_survivor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Delete: a read state unlinks the range and clears entry low, then the alive sweep clears
// low+1..high at one entry per cycle, then the finish state loads the output register.
// A rejected range goes to the finish state without a sweep. Restart is set by the
// one-entry-per-cycle relink sweep over all SLOTS entries of the link and alive memories.
// After reset the same relink sweep runs with in_stall high.

module range_delete_nearest_survivor_unit
	import rdns_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [FIELD_W-1:0] cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               func,
	input  wire logic [FIELD_W-1:0] range_low,
	input  wire logic [FIELD_W-1:0] range_high,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FIELD_W-1:0]      left_survivor,
	output logic [FIELD_W-1:0]      right_survivor,
	output logic                    bad_range
);

	typedef enum logic [2:0] {
		ST_RELINK,
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [FIELD_W-1:0] num_entries_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [FIELD_W-1:0] res_left_q;
	logic [FIELD_W-1:0] res_right_q;
	logic               res_bad_q;
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_left_q;
	logic [FIELD_W-1:0] out_right_q;
	logic               out_bad_q;

	logic [IDX_W-1:0] prev_mem  [SLOTS];
	logic [IDX_W-1:0] next_mem  [SLOTS];
	logic             alive_mem [SLOTS];

	logic [IDX_W-1:0] rd_prev_q;
	logic [IDX_W-1:0] rd_next_q;
	logic             rd_alive_lo_q;
	logic             rd_alive_hi_q;

	logic             prev_we, next_we, alive_we;
	logic [IDX_W-1:0] prev_wa, next_wa, alive_wa;
	logic [IDX_W-1:0] prev_wd, next_wd;
	logic             alive_wd;

	logic             accept;
	logic             bounds_bad;
	logic             ends_dead;
	logic             out_free;
	logic [IDX_W-1:0] in_lo_idx;
	logic [IDX_W-1:0] in_hi_idx;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_lo_idx = IDX_W'(range_low);
	assign in_hi_idx = IDX_W'(range_high);
	assign bounds_bad = (range_low == '0) || (range_high < range_low)
		|| (int'(range_high) > int'(len_q));
	assign ends_dead = !rd_alive_lo_q || !rd_alive_hi_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign left_survivor  = out_left_q;
	assign right_survivor = out_right_q;
	assign bad_range      = out_bad_q;

	// write ports
	always_comb begin
		prev_we  = 1'b0;
		next_we  = 1'b0;
		alive_we = 1'b0;
		prev_wa  = ptr_q;
		next_wa  = ptr_q;
		alive_wa = ptr_q;
		prev_wd  = (ptr_q == '0) ? '0 : ptr_q - IDX_W'(1);
		next_wd  = (ptr_q == IDX_W'(SLOTS - 1)) ? ptr_q : ptr_q + IDX_W'(1);
		alive_wd = (ptr_q != '0) && (int'(ptr_q) <= int'(len_q));
		unique case (state_q)
			ST_RELINK: begin
				prev_we  = 1'b1;
				next_we  = 1'b1;
				alive_we = 1'b1;
			end
			ST_READ: begin
				if (!ends_dead) begin
					next_we  = 1'b1;
					next_wa  = rd_prev_q;
					next_wd  = rd_next_q;
					prev_we  = 1'b1;
					prev_wa  = rd_next_q;
					prev_wd  = rd_prev_q;
					alive_we = 1'b1;
					alive_wa = lo_q;
					alive_wd = 1'b0;
				end
			end
			ST_SWEEP: begin
				alive_we = 1'b1;
				alive_wd = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (alive_we) begin
			alive_mem[alive_wa] <= alive_wd;
		end
		rd_prev_q     <= prev_mem[in_lo_idx];
		rd_next_q     <= next_mem[in_hi_idx];
		rd_alive_lo_q <= alive_mem[in_lo_idx];
		rd_alive_hi_q <= alive_mem[in_hi_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_entries_q <= FIELD_W'(NUM_RST);
		end else if (cfg_wr_en) begin
			num_entries_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RELINK;
			ptr_q       <= '0;
			len_q       <= clamp_len(FIELD_W'(NUM_RST));
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RELINK: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (ptr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						lo_q <= in_lo_idx;
						hi_q <= in_hi_idx;
						if (func == FUNC_RESTART) begin
							len_q   <= clamp_len(num_entries_q);
							ptr_q   <= '0;
							state_q <= ST_RELINK;
						end else if (bounds_bad) begin
							res_left_q  <= '0;
							res_right_q <= '0;
							res_bad_q   <= 1'b1;
							state_q     <= ST_FIN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (ends_dead) begin
						res_left_q  <= '0;
						res_right_q <= '0;
						res_bad_q   <= 1'b1;
						state_q     <= ST_FIN;
					end else begin
						res_left_q <= (rd_prev_q != '0 && int'(rd_prev_q) <= int'(len_q))
							? FIELD_W'(rd_prev_q) : '0;
						res_right_q <= (rd_next_q != '0 && int'(rd_next_q) <= int'(len_q))
							? FIELD_W'(rd_next_q) : '0;
						res_bad_q <= 1'b0;
						ptr_q     <= lo_q + IDX_W'(1);
						state_q   <= (lo_q == hi_q) ? ST_FIN : ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (ptr_q == hi_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_left_q  <= res_left_q;
						out_right_q <= res_right_q;
						out_bad_q   <= res_bad_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result beat raised outside finish state");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_bad_q) |-> (out_left_q == '0 && out_right_q == '0))
		else $error("rejected range carries survivors");

	a_left_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && !ends_dead) |-> (rd_prev_q < lo_q))
		else $error("left link not below range");

	a_right_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && !ends_dead) |-> (rd_next_q > hi_q))
		else $error("right link not above range");
`endif

endmodule

`default_nettype wire
